@@ sv/trc_pkg.sv @@
`timescale 1ns / 1ps
package trc_pkg;

    typedef struct packed {
        logic              issue_valid;
        logic [2:0]        opcode;
        logic [2:0]        dest_idx;
        logic [2:0]        src1_reg;
        logic [2:0]        src2_reg;
        logic signed [15:0] offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         issue_status;
        logic               commit_valid;
        logic [2:0]         commit_reg;
        logic signed [31:0] commit_value;
        logic               rob_empty;
    } out_item_t;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_LEA = 3'd4;

    localparam logic [1:0] ISS_OK       = 2'd0;
    localparam logic [1:0] ISS_ROB_FULL = 2'd1;
    localparam logic [1:0] ISS_RS_FULL  = 2'd2;
    localparam logic [1:0] ISS_NONE     = 2'd3;

    localparam logic [1:0] CFG_ALU_LAT = 2'd0;
    localparam logic [1:0] CFG_MUL_LAT = 2'd1;
    localparam logic [1:0] CFG_DIV_LAT = 2'd2;

    typedef struct packed {
        logic accept;
        logic src1;
        logic src2;
        logic exec;
        logic mul_wb;
        logic div_start;
        logic div_wb;
        logic wake;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic issue_ok;
        logic fin_mul;
        logic fin_div;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

@@ sv/trc_div.sv @@
`timescale 1ns / 1ps
module trc_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic          neg_reg;
    logic [W:0]    shifted;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;

    assign mag_a   = dividend[W-1] ? W'(-dividend) : dividend;
    assign mag_b   = divisor[W-1] ? W'(-divisor) : divisor;
    assign shifted = {rem_reg, quo_reg[W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (divisor == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= (divisor == '0) ? '0 : mag_a;
            rem_reg <= '0;
            dvs_reg <= mag_b;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
            cnt_reg <= CW'(W);
        end else if (busy_reg) begin
            // one restoring step per cycle
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_reg <= W'(shifted - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? W'(-quo_reg) : quo_reg;

endmodule

@@ sv/trc_dpath.sv @@
`timescale 1ns / 1ps
module trc_dpath #(
    parameter int STATION_COUNT = 4,
    parameter int ROB_DEPTH     = 4,
    parameter int REG_COUNT     = 8,
    parameter int DATA_WIDTH    = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_wr_data,
    input  trc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output trc_pkg::out_item_t  m_data,
    input  trc_pkg::cmd_t       cmd,
    input  logic [((STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1)-1:0] st_idx,
    input  logic [$clog2(ROB_DEPTH)-1:0] rb_idx,
    output trc_pkg::sts_t       sts
);
    localparam int STW = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
    localparam int SW  = $clog2(ROB_DEPTH);
    localparam int OW  = $clog2(ROB_DEPTH + 1);
    localparam int RIW = $clog2(REG_COUNT);
    localparam int DW  = DATA_WIDTH;

    trc_pkg::in_item_t  in_reg;
    trc_pkg::out_item_t m_data_reg;
    logic               m_valid_reg;
    logic [3:0]         alu_lat_reg, mul_lat_reg, div_lat_reg;
    logic [1:0]         status_reg;
    logic [STW-1:0]     alloc_reg;
    logic [DW-1:0]      prod_reg;

    logic [STATION_COUNT-1:0] st_busy_reg, st_pj_reg, st_pk_reg;
    logic [2:0]     st_op_reg   [STATION_COUNT];
    logic [SW-1:0]  st_wj_reg   [STATION_COUNT];
    logic [SW-1:0]  st_wk_reg   [STATION_COUNT];
    logic [DW-1:0]  st_vj_reg   [STATION_COUNT];
    logic [DW-1:0]  st_vk_reg   [STATION_COUNT];
    logic [SW-1:0]  st_slot_reg [STATION_COUNT];
    logic [3:0]     st_cyc_reg  [STATION_COUNT];

    logic [ROB_DEPTH-1:0] rob_use_reg, rob_rdy_reg;
    logic [RIW-1:0] rob_dst_reg  [ROB_DEPTH];
    logic [DW-1:0]  rob_val_reg  [ROB_DEPTH];
    logic [DW-1:0]  rf_reg       [REG_COUNT];
    logic [SW-1:0]  head_reg, tail_reg;
    logic [OW-1:0]  occ_reg;

    function automatic logic [RIW-1:0] red_idx(input logic [2:0] r);
        logic [5:0] v;
        v = {3'b000, r};
        for (int i = 0; i < 4; i++) begin
            if (v >= 6'(REG_COUNT)) v = v - 6'(REG_COUNT);
        end
        return v[RIW-1:0];
    endfunction

    // issue check
    logic           free_any;
    logic [STW-1:0] free_idx;
    logic [1:0]     issue_st;

    always_comb begin
        free_any = ~&st_busy_reg;
        free_idx = '0;
        for (int i = STATION_COUNT - 1; i >= 0; i--) begin
            if (!st_busy_reg[i]) free_idx = STW'(i);
        end
        if (!in_reg.issue_valid || in_reg.opcode > trc_pkg::OP_LEA) begin
            issue_st = trc_pkg::ISS_NONE;
        end else if (occ_reg >= OW'(ROB_DEPTH)) begin
            issue_st = trc_pkg::ISS_ROB_FULL;
        end else if (!free_any) begin
            issue_st = trc_pkg::ISS_RS_FULL;
        end else begin
            issue_st = trc_pkg::ISS_OK;
        end
    end

    // rename: youngest in-flight producer wins
    logic [RIW-1:0] ren_reg;
    logic [6:0]     ren_t;
    logic           ren_found;
    logic [SW-1:0]  ren_slot;
    logic           ren_pend;
    logic [DW-1:0]  ren_val;

    always_comb begin
        ren_reg   = cmd.src2 ? red_idx(in_reg.src2_reg) : red_idx(in_reg.src1_reg);
        ren_found = 1'b0;
        ren_slot  = '0;
        ren_t     = '0;
        for (int k = ROB_DEPTH; k >= 1; k--) begin
            ren_t = 7'(tail_reg) + 7'(ROB_DEPTH - k);
            if (ren_t >= 7'(ROB_DEPTH)) ren_t = ren_t - 7'(ROB_DEPTH);
            if (7'(k) <= 7'(occ_reg) && rob_use_reg[ren_t[SW-1:0]]
                    && rob_dst_reg[ren_t[SW-1:0]] == ren_reg) begin
                ren_found = 1'b1;
                ren_slot  = ren_t[SW-1:0];
            end
        end
        ren_pend = ren_found && !rob_rdy_reg[ren_slot];
        ren_val  = ren_found ? rob_val_reg[ren_slot] : rf_reg[ren_reg];
    end

    logic [DW+15:0] off_wide;
    logic [DW-1:0]  off_ext;
    assign off_wide = {{DW{in_reg.offset[15]}}, in_reg.offset};
    assign off_ext  = off_wide[DW-1:0];

    // execute step for the selected station
    logic [2:0]    cur_op;
    logic [DW-1:0] cur_a, cur_b, alu_res;
    logic [3:0]    lat_sel, lat_eff, cyc_load, cyc_new;
    logic          cur_rdy, fin, fin_raw, div_done;
    logic [DW-1:0] div_q;
    logic          wb_en;
    logic [DW-1:0] wb_val;
    logic [SW-1:0] wb_slot;

    always_comb begin
        cur_op  = st_op_reg[st_idx];
        cur_a   = st_vj_reg[st_idx];
        cur_b   = st_vk_reg[st_idx];
        cur_rdy = st_busy_reg[st_idx] && !st_pj_reg[st_idx] && !st_pk_reg[st_idx];
        case (cur_op)
            trc_pkg::OP_MUL: lat_sel = mul_lat_reg;
            trc_pkg::OP_DIV: lat_sel = div_lat_reg;
            default:         lat_sel = alu_lat_reg;
        endcase
        lat_eff  = (lat_sel == 4'd0) ? 4'd1 : lat_sel;
        cyc_load = (st_cyc_reg[st_idx] == 4'd0) ? lat_eff : st_cyc_reg[st_idx];
        cyc_new  = cyc_load - 4'd1;
        fin_raw  = cur_rdy && cyc_new == 4'd0;
        fin      = cmd.exec && fin_raw;
        alu_res  = (cur_op == trc_pkg::OP_SUB) ? cur_a - cur_b : cur_a + cur_b;
        wb_slot  = st_slot_reg[st_idx];
        wb_en    = 1'b0;
        wb_val   = alu_res;
        if (fin && cur_op != trc_pkg::OP_MUL && cur_op != trc_pkg::OP_DIV) begin
            wb_en = 1'b1;
        end else if (cmd.mul_wb) begin
            wb_en  = 1'b1;
            wb_val = prod_reg;
        end else if (cmd.div_wb) begin
            wb_en  = 1'b1;
            wb_val = div_q;
        end
    end

    trc_div #(.W(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cur_a),
        .divisor  (cur_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // commit
    logic          com;
    logic [OW-1:0] occ_after;
    assign com       = cmd.commit && rob_use_reg[head_reg] && rob_rdy_reg[head_reg];
    assign occ_after = com ? occ_reg - 1'b1 : occ_reg;

    always_comb begin
        sts.issue_ok = (issue_st == trc_pkg::ISS_OK);
        sts.fin_mul  = fin_raw && cur_op == trc_pkg::OP_MUL;
        sts.fin_div  = fin_raw && cur_op == trc_pkg::OP_DIV;
        sts.div_done = div_done;
        sts.out_free = !m_valid_reg || m_ready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alu_lat_reg <= 4'd1;
            mul_lat_reg <= 4'd2;
            div_lat_reg <= 4'd2;
            st_busy_reg <= '0;
            st_pj_reg   <= '0;
            st_pk_reg   <= '0;
            for (int i = 0; i < STATION_COUNT; i++) st_cyc_reg[i] <= 4'd0;
            rob_use_reg <= '0;
            rob_rdy_reg <= '0;
            for (int r = 0; r < REG_COUNT; r++) rf_reg[r] <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    trc_pkg::CFG_ALU_LAT: alu_lat_reg <= cfg_wr_data;
                    trc_pkg::CFG_MUL_LAT: mul_lat_reg <= cfg_wr_data;
                    trc_pkg::CFG_DIV_LAT: div_lat_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.src1 && issue_st == trc_pkg::ISS_OK) begin
                st_busy_reg[free_idx] <= 1'b1;
                st_pj_reg[free_idx]   <= ren_pend;
                st_cyc_reg[free_idx]  <= 4'd0;
            end
            if (cmd.src2) begin
                st_pk_reg[alloc_reg] <= (in_reg.opcode == trc_pkg::OP_LEA) ? 1'b0 : ren_pend;
                rob_use_reg[tail_reg] <= 1'b1;
                rob_rdy_reg[tail_reg] <= 1'b0;
                tail_reg <= (tail_reg == SW'(ROB_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                occ_reg  <= occ_reg + 1'b1;
            end
            if (cmd.exec && cur_rdy) st_cyc_reg[st_idx] <= cyc_new;
            if (wb_en) begin
                rob_rdy_reg[wb_slot] <= 1'b1;
                st_busy_reg[st_idx]  <= 1'b0;
            end
            if (cmd.wake && rob_use_reg[rb_idx] && rob_rdy_reg[rb_idx]) begin
                for (int i = 0; i < STATION_COUNT; i++) begin
                    if (st_busy_reg[i] && st_pj_reg[i] && st_wj_reg[i] == rb_idx)
                        st_pj_reg[i] <= 1'b0;
                    if (st_busy_reg[i] && st_pk_reg[i] && st_wk_reg[i] == rb_idx)
                        st_pk_reg[i] <= 1'b0;
                end
            end
            if (com) begin
                rf_reg[rob_dst_reg[head_reg]] <= rob_val_reg[head_reg];
                rob_use_reg[head_reg] <= 1'b0;
                rob_rdy_reg[head_reg] <= 1'b0;
                head_reg <= (head_reg == SW'(ROB_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                occ_reg  <= occ_after;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) in_reg <= s_data;
        if (cmd.src1) begin
            status_reg <= issue_st;
            alloc_reg  <= free_idx;
            if (issue_st == trc_pkg::ISS_OK) begin
                st_op_reg[free_idx]   <= in_reg.opcode;
                st_wj_reg[free_idx]   <= ren_slot;
                st_vj_reg[free_idx]   <= ren_val;
                st_slot_reg[free_idx] <= tail_reg;
            end
        end
        if (cmd.src2) begin
            st_wk_reg[alloc_reg] <= ren_slot;
            st_vk_reg[alloc_reg] <= (in_reg.opcode == trc_pkg::OP_LEA) ? off_ext : ren_val;
            rob_dst_reg[tail_reg] <= red_idx(in_reg.dest_idx);
        end
        if (fin) prod_reg <= DW'(cur_a * cur_b);
        if (wb_en) rob_val_reg[wb_slot] <= wb_val;
        if (cmd.wake && rob_use_reg[rb_idx] && rob_rdy_reg[rb_idx]) begin
            for (int i = 0; i < STATION_COUNT; i++) begin
                if (st_busy_reg[i] && st_pj_reg[i] && st_wj_reg[i] == rb_idx)
                    st_vj_reg[i] <= rob_val_reg[rb_idx];
                if (st_busy_reg[i] && st_pk_reg[i] && st_wk_reg[i] == rb_idx)
                    st_vk_reg[i] <= rob_val_reg[rb_idx];
            end
        end
        if (cmd.commit) begin
            m_data_reg.issue_status <= status_reg;
            m_data_reg.commit_valid <= com;
            m_data_reg.commit_reg   <= com ? 3'(rob_dst_reg[head_reg]) : 3'd0;
            m_data_reg.commit_value <= com ? 32'(rob_val_reg[head_reg]) : 32'd0;
            m_data_reg.rob_empty    <= (occ_after == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OW'(ROB_DEPTH))
        else $error("rob occupancy above depth");

    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(rob_use_reg) == int'(occ_reg))
        else $error("rob occupancy out of step with in-use entries");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (m_data_reg.rob_empty == (occ_reg == '0)))
        else $error("rob_empty disagrees with occupancy");

endmodule

@@ sv/trc_ctrl.sv @@
`timescale 1ns / 1ps
module trc_ctrl #(
    parameter int STATION_COUNT = 4,
    parameter int ROB_DEPTH     = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  trc_pkg::sts_t sts,
    output trc_pkg::cmd_t cmd,
    output logic [((STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1)-1:0] st_idx,
    output logic [$clog2(ROB_DEPTH)-1:0] rb_idx
);
    localparam int STW = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
    localparam int SW  = $clog2(ROB_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRC1   = 3'd1;
    localparam logic [2:0] S_SRC2   = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_WAKE   = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0]     state_reg, state_next;
    logic [STW-1:0] st_reg, st_next;
    logic [SW-1:0]  rb_reg, rb_next;
    logic           st_last;

    assign st_last = (st_reg == STW'(STATION_COUNT - 1));

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        st_next    = st_reg;
        rb_next    = rb_reg;
        s_ready    = 1'b0;
        unique case (state_reg) inside
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_SRC1;
                end
            end
            S_SRC1: begin
                cmd.src1   = 1'b1;
                st_next    = '0;
                state_next = sts.issue_ok ? S_SRC2 : S_EXEC;
            end
            S_SRC2: begin
                cmd.src2   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.fin_mul) begin
                    state_next = S_MUL;
                end else if (sts.fin_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else if (st_last) begin
                    rb_next    = '0;
                    state_next = S_WAKE;
                end else begin
                    st_next = st_reg + 1'b1;
                end
            end
            S_MUL, S_DIV: begin
                if (state_reg == S_MUL || sts.div_done) begin
                    cmd.mul_wb = (state_reg == S_MUL);
                    cmd.div_wb = (state_reg == S_DIV);
                    if (st_last) begin
                        rb_next    = '0;
                        state_next = S_WAKE;
                    end else begin
                        st_next    = st_reg + 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end
            S_WAKE: begin
                cmd.wake = 1'b1;
                if (rb_reg == SW'(ROB_DEPTH - 1)) begin
                    state_next = S_COMMIT;
                end else begin
                    rb_next = rb_reg + 1'b1;
                end
            end
            S_COMMIT: begin
                // hold until the result register can take the result
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= '0;
            rb_reg    <= '0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            rb_reg    <= rb_next;
        end
    end

    assign st_idx = st_reg;
    assign rb_idx = rb_reg;

    // the divider start rides along with the execute step
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.src1, cmd.src2, cmd.exec, cmd.mul_wb,
                  cmd.div_wb, cmd.wake, cmd.commit}))
        else $error("more than one datapath command");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> state_reg == S_DIV)
        else $error("divide started outside its wait state");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("result loaded while previous one still held");

endmodule

@@ sv/tomasulo_rob_core.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// config    in   cfg_wr_en          cfg_index (2b), cfg_wr_data (4b)
// request   in   s_valid/s_ready    s_data   (trc_pkg::in_item_t)
// result    out  m_valid/m_ready    m_data   (trc_pkg::out_item_t)
//
// One request is one machine cycle and gives exactly one result.
// Steps per request: accept, first source, second source (only when it issues),
// one execute step per station, a wait per multiply that finishes and a wait
// on the bit-serial divider per divide that finishes (no shift steps for a zero
// divisor), one wake step per reorder buffer entry, then the commit step.
// A new request is taken while the previous result waits in the output register;
// the commit step holds until that register is free.
// aresetn is synchronous, active low; latencies return to 1, 2, 2.
module tomasulo_rob_core #(
    parameter int STATION_COUNT = 4,
    parameter int ROB_DEPTH     = 4,
    parameter int REG_COUNT     = 8,
    parameter int DATA_WIDTH    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  trc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output trc_pkg::out_item_t m_data
);
    localparam int STW = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
    localparam int SW  = $clog2(ROB_DEPTH);

    trc_pkg::cmd_t  cmd;
    trc_pkg::sts_t  sts;
    logic [STW-1:0] st_idx;
    logic [SW-1:0]  rb_idx;

    trc_ctrl #(
        .STATION_COUNT (STATION_COUNT),
        .ROB_DEPTH     (ROB_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .st_idx  (st_idx),
        .rb_idx  (rb_idx)
    );

    trc_dpath #(
        .STATION_COUNT (STATION_COUNT),
        .ROB_DEPTH     (ROB_DEPTH),
        .REG_COUNT     (REG_COUNT),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .st_idx      (st_idx),
        .rb_idx      (rb_idx),
        .sts         (sts)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

    // Machine state mirror used to predict each cycle's commit result.
    class rob_scoreboard;
        logic [3:0]  lat [3];
        bit          rs_busy [4];
        logic [2:0]  rs_op [4];
        bit          rs_pend_j [4];
        bit          rs_pend_k [4];
        logic [1:0]  rs_tag_j [4];
        logic [1:0]  rs_tag_k [4];
        logic [31:0] rs_val_j [4];
        logic [31:0] rs_val_k [4];
        logic [1:0]  rs_slot [4];
        logic [3:0]  rs_left [4];
        bit          rob_used [4];
        bit          rob_done [4];
        logic [2:0]  rob_dst [4];
        logic [31:0] rob_val [4];
        logic [31:0] regs [8];
        logic [1:0]  head;
        logic [1:0]  tail;
        int          occ;
        trc_pkg::out_item_t pending [$];
        int          errors;
        int          commits;
        int          stalls;

        function new();
            lat[0] = 1; lat[1] = 2; lat[2] = 2;
            for (int i = 0; i < 4; i++) begin
                rs_busy[i] = 0; rs_pend_j[i] = 0; rs_pend_k[i] = 0; rs_left[i] = 0;
                rob_used[i] = 0; rob_done[i] = 0;
            end
            for (int i = 0; i < 8; i++) regs[i] = 0;
            head = 0; tail = 0; occ = 0; errors = 0; commits = 0; stalls = 0;
        endfunction

        function void rename(input logic [2:0] r, output bit pend,
                             output logic [1:0] tag, output logic [31:0] v);
            logic [1:0] sl;
            pend = 0; tag = 0; v = regs[r];
            for (int k = 1; k <= occ; k++) begin
                sl = tail - 2'(k);
                if (rob_used[sl] && rob_dst[sl] == r) begin
                    if (rob_done[sl]) v = rob_val[sl];
                    else begin
                        pend = 1; tag = sl; v = 0;
                    end
                    return;
                end
            end
        endfunction

        function logic [31:0] alu(input logic [2:0] op, input logic [31:0] a,
                                  input logic [31:0] b);
            logic [31:0] ma, mb, q;
            case (op)
                trc_pkg::OP_SUB: return a - b;
                trc_pkg::OP_MUL: return a * b;
                trc_pkg::OP_DIV: begin
                    if (b == 0) return 0;
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    return (a[31] != b[31]) ? -q : q;
                end
                default: return a + b;
            endcase
        endfunction

        function void note_request(input trc_pkg::in_item_t it);
            trc_pkg::out_item_t r;
            int s;
            logic [3:0] l;
            r = '0;
            s = -1;
            if (!it.issue_valid || it.opcode > trc_pkg::OP_LEA)
                r.issue_status = trc_pkg::ISS_NONE;
            else if (occ >= 4) r.issue_status = trc_pkg::ISS_ROB_FULL;
            else begin
                for (int i = 3; i >= 0; i--) if (!rs_busy[i]) s = i;
                if (s < 0) r.issue_status = trc_pkg::ISS_RS_FULL;
                else r.issue_status = trc_pkg::ISS_OK;
            end
            if (r.issue_status inside {trc_pkg::ISS_ROB_FULL, trc_pkg::ISS_RS_FULL})
                stalls++;
            if (r.issue_status == trc_pkg::ISS_OK) begin
                rename(it.src1_reg, rs_pend_j[s], rs_tag_j[s], rs_val_j[s]);
                if (it.opcode == trc_pkg::OP_LEA) begin
                    rs_val_k[s] = 32'(it.offset); rs_pend_k[s] = 0; rs_tag_k[s] = 0;
                end else rename(it.src2_reg, rs_pend_k[s], rs_tag_k[s], rs_val_k[s]);
                rob_used[tail] = 1; rob_done[tail] = 0;
                rob_dst[tail] = it.dest_idx; rob_val[tail] = 0;
                rs_busy[s] = 1; rs_op[s] = it.opcode; rs_slot[s] = tail; rs_left[s] = 0;
                tail++; occ++;
            end
            for (int i = 0; i < 4; i++) begin
                if (!rs_busy[i] || rs_pend_j[i] || rs_pend_k[i]) continue;
                if (rs_left[i] == 0) begin
                    l = (rs_op[i] == trc_pkg::OP_MUL) ? lat[trc_pkg::CFG_MUL_LAT] :
                        (rs_op[i] == trc_pkg::OP_DIV) ? lat[trc_pkg::CFG_DIV_LAT] :
                                                        lat[trc_pkg::CFG_ALU_LAT];
                    rs_left[i] = (l == 0) ? 4'd1 : l;
                end
                rs_left[i]--;
                if (rs_left[i] != 0) continue;
                rob_val[rs_slot[i]] = alu(rs_op[i], rs_val_j[i], rs_val_k[i]);
                rob_done[rs_slot[i]] = 1;
                rs_busy[i] = 0;
            end
            for (int e = 0; e < 4; e++) begin
                if (!rob_used[e] || !rob_done[e]) continue;
                for (int i = 0; i < 4; i++) begin
                    if (!rs_busy[i]) continue;
                    if (rs_pend_j[i] && rs_tag_j[i] == e) begin
                        rs_val_j[i] = rob_val[e]; rs_pend_j[i] = 0;
                    end
                    if (rs_pend_k[i] && rs_tag_k[i] == e) begin
                        rs_val_k[i] = rob_val[e]; rs_pend_k[i] = 0;
                    end
                end
            end
            if (rob_used[head] && rob_done[head]) begin
                regs[rob_dst[head]] = rob_val[head];
                r.commit_valid = 1; r.commit_reg = rob_dst[head];
                r.commit_value = rob_val[head];
                rob_used[head] = 0; rob_done[head] = 0;
                head++;
                if (occ > 0) occ--;
                commits++;
            end
            r.rob_empty = (occ == 0);
            pending.push_back(r);
        endfunction

        function void check_result(input trc_pkg::out_item_t got);
            trc_pkg::out_item_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp status=%0d cv=%0d reg=%0d val=%0d empty=%0d",
                             e.issue_status, e.commit_valid, e.commit_reg,
                             e.commit_value, e.rob_empty);
                    $display("          got status=%0d cv=%0d reg=%0d val=%0d empty=%0d",
                             got.issue_status, got.commit_valid, got.commit_reg,
                             got.commit_value, got.rob_empty);
                end
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [1:0] cfg_index;
    logic [3:0] cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    trc_pkg::in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    trc_pkg::out_item_t m_data;

    rob_scoreboard sb;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_sink;
    int  n_sent;

    tomasulo_rob_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_request(input trc_pkg::in_item_t it);
        while (!no_idle && $urandom_range(99) < 7) @(posedge aclk);
        s_valid <= 1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
        n_sent++;
        s_valid <= 0;
        // drop valid before the next request
        @(posedge aclk);
    endtask

    task automatic write_latency(input logic [1:0] idx, input logic [3:0] v);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.lat[idx] = v;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic trc_pkg::in_item_t rand_request(input bit sane);
        trc_pkg::in_item_t it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(trc_pkg::in_item_t)-1:0];
        if (sane) begin
            it.issue_valid = ($urandom_range(9) != 0);
            it.opcode = 3'($urandom_range(4));
            // keep dependency chains short and common
            it.dest_idx = 3'($urandom_range(3));
            it.src1_reg = 3'($urandom_range(3));
            it.src2_reg = $urandom_range(3) == 0 ? 3'($urandom) : 3'($urandom_range(3));
            if ($urandom_range(3) == 0)
                it.offset = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        return it;
    endfunction

    function automatic trc_pkg::in_item_t mk(input logic [2:0] op, input logic [2:0] d,
                                             input logic [2:0] a, input logic [2:0] b,
                                             input logic signed [15:0] off);
        trc_pkg::in_item_t it;
        it.issue_valid = 1; it.opcode = op; it.dest_idx = d;
        it.src1_reg = a; it.src2_reg = b; it.offset = off;
        return it;
    endfunction

    // result side: random stalls, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= !hold_sink && (no_idle || $urandom_range(99) >= 7);
        end
    end

    // hold the result side off once, after 350 requests have been sent
    initial begin
        wait (n_sent >= 350);
        @(posedge aclk);
        hold_sink <= 1;
        repeat (400) @(posedge aclk);
        hold_sink <= 0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        trc_pkg::in_item_t it;
        sb = new();
        aresetn = 0; cfg_wr_en = 0; cfg_index = 0; cfg_wr_data = 0;
        s_valid = 0; s_data = '0; no_idle = 0; n_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: load extremes, each operation, wraparound, div special cases
        send_request(mk(trc_pkg::OP_LEA, 1, 0, 0, 16'sh7fff));
        send_request(mk(trc_pkg::OP_LEA, 2, 0, 0, 16'sh8000));
        send_request(mk(trc_pkg::OP_LEA, 3, 0, 0, -16'sd1));
        send_request(mk(trc_pkg::OP_ADD, 4, 1, 1, 0));
        send_request(mk(trc_pkg::OP_SUB, 5, 2, 1, 0));
        send_request(mk(trc_pkg::OP_MUL, 6, 2, 2, 0));
        send_request(mk(trc_pkg::OP_MUL, 7, 6, 6, 0));
        send_request(mk(trc_pkg::OP_DIV, 0, 7, 3, 0));
        send_request(mk(trc_pkg::OP_DIV, 4, 1, 0, 0));
        send_request(mk(trc_pkg::OP_DIV, 5, 5, 3, 0));
        send_request(mk(trc_pkg::OP_ADD, 1, 1, 1, 0));
        send_request(mk(trc_pkg::OP_SUB, 2, 2, 7, 0));
        it = mk(trc_pkg::OP_ADD, 0, 0, 0, 0); it.opcode = 3'd5; send_request(it);
        it.opcode = 3'd7; send_request(it);
        it = mk(trc_pkg::OP_ADD, 7, 7, 7, 0); it.issue_valid = 0; send_request(it);
        for (int i = 0; i < 8; i++)
            send_request(mk(trc_pkg::OP_MUL, 3'(i), 3'(i), 3'(i + 1), 0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_latency(trc_pkg::CFG_ALU_LAT, 0);
                    write_latency(trc_pkg::CFG_MUL_LAT, 0);
                    write_latency(trc_pkg::CFG_DIV_LAT, 0);
                end
                1: begin
                    write_latency(trc_pkg::CFG_ALU_LAT, 15);
                    write_latency(trc_pkg::CFG_MUL_LAT, 15);
                    write_latency(trc_pkg::CFG_DIV_LAT, 15);
                end
                2: begin
                    write_latency(trc_pkg::CFG_ALU_LAT, 1);
                    write_latency(trc_pkg::CFG_MUL_LAT, 1);
                    write_latency(trc_pkg::CFG_DIV_LAT, 1);
                end
                default: begin
                    write_latency(trc_pkg::CFG_ALU_LAT, 4'($urandom));
                    write_latency(trc_pkg::CFG_MUL_LAT, 4'($urandom));
                    write_latency(trc_pkg::CFG_DIV_LAT, 4'($urandom));
                end
            endcase
            no_idle = (ph == 3);
            for (int i = 0; i < 310; i++) begin
                send_request(rand_request($urandom_range(9) != 0));
            end
            no_idle = 0;
            // sender pauses until every result is back
            drain();
        end

        $display("Run covered %0d requests over 7 latency settings: %0d commits, %0d issue stalls.",
                 n_sent, sb.commits, sb.stalls);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
sv/trc_pkg.sv
sv/trc_div.sv
sv/trc_dpath.sv
sv/trc_ctrl.sv
sv/tomasulo_rob_core.sv
tb/tb.sv
